### rtl/ddgs_pkg.sv
// Package for the differential-drive goal steering block.
// Holds the controller command and status types, the CORDIC arc table and constants.
// No dependencies.
package ddgs_pkg;

  localparam int unsigned PowerMax = 25600;
  localparam int unsigned TwoPiQ16 = 411775;
  localparam int unsigned MaxSteps = 24;

  localparam logic [1:0] RegAngGain = 2'd0;
  localparam logic [1:0] RegLinGain = 2'd1;
  localparam logic [1:0] RegSlew    = 2'd2;
  localparam logic [1:0] RegLook    = 2'd3;

  typedef enum logic [3:0] {
    StIdle,
    StCordic,
    StProd1,
    StProd2,
    StTerm,
    StSqrt,
    StDiv,
    StMix,
    StSlew,
    StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic cordic_step;
    logic prod1;
    logic prod2;
    logic terms;
    logic sqrt_step;
    logic div_step;
    logic mix;
    logic slew;
  } cmd_t;

  typedef struct packed {
    logic cordic_done;
    logic sqrt_done;
    logic div_done;
    logic stop;
  } sts_t;

  function automatic logic [31:0] arc_of(input logic [4:0] i);
    logic [31:0] a;
    begin
      case (i)
        5'd0: a = 32'h20000000;  5'd1: a = 32'h12E4051E;
        5'd2: a = 32'h09FB385B;  5'd3: a = 32'h051111D4;
        5'd4: a = 32'h028B0D43;  5'd5: a = 32'h0145D7E1;
        5'd6: a = 32'h00A2F61E;  5'd7: a = 32'h00517C55;
        5'd8: a = 32'h0028BE53;  5'd9: a = 32'h00145F2F;
        5'd10: a = 32'h000A2F98; 5'd11: a = 32'h000517CC;
        5'd12: a = 32'h00028BE6; 5'd13: a = 32'h000145F3;
        5'd14: a = 32'h0000A2FA; 5'd15: a = 32'h0000517D;
        5'd16: a = 32'h000028BE; 5'd17: a = 32'h0000145F;
        5'd18: a = 32'h00000A30; 5'd19: a = 32'h00000518;
        5'd20: a = 32'h0000028C; 5'd21: a = 32'h00000146;
        5'd22: a = 32'h000000A3; 5'd23: a = 32'h00000051;
        default: a = 32'h0;
      endcase
      return a;
    end
  endfunction

endpackage

### rtl/ddgs_ctrl.sv
// Controller state machine of the goal steering block.
// Steps the datapath: CORDIC, products, sqrt and divide on a stop, mix, slew; uses ddgs_pkg.
module ddgs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ddgs_pkg::sts_t sts_i,
  output ddgs_pkg::cmd_t cmd_o
);
  import ddgs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:   if (in_valid_i) state_d = StCordic;
      StCordic: if (sts_i.cordic_done) state_d = StProd1;
      StProd1:  state_d = StProd2;
      StProd2:  state_d = StTerm;
      StTerm:   state_d = sts_i.stop ? StSqrt : StMix;
      StSqrt:   if (sts_i.sqrt_done) state_d = StDiv;
      StDiv:    if (sts_i.div_done) state_d = StMix;
      StMix:    state_d = StSlew;
      StSlew:   state_d = StOut;
      StOut:    if (out_ready_i) state_d = StIdle;
      default:  state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      StCordic: cmd_o.cordic_step = 1'b1;
      StProd1:  cmd_o.prod1 = 1'b1;
      StProd2:  cmd_o.prod2 = 1'b1;
      StTerm:   cmd_o.terms = 1'b1;
      StSqrt:   cmd_o.sqrt_step = 1'b1;
      StDiv:    cmd_o.div_step = 1'b1;
      StMix:    cmd_o.mix = 1'b1;
      StSlew:   cmd_o.slew = 1'b1;
      StOut:    out_valid_o = 1'b1;
      default:  cmd_o = '0;
    endcase
  end

endmodule

### rtl/ddgs_dp.sv
// Datapath of the goal steering block: CORDIC, multipliers, square root, divider, slew.
// Driven by ddgs_ctrl through cmd_t; uses ddgs_pkg.
module ddgs_dp #(
  parameter int unsigned CordicSteps = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddgs_pkg::cmd_t     cmd_i,
  output ddgs_pkg::sts_t     sts_o,
  input  logic [11:0]        ang_gain_i,
  input  logic [11:0]        lin_gain_i,
  input  logic [11:0]        slew_rate_i,
  input  logic [14:0]        look_i,
  input  logic signed [15:0] robot_x_i,
  input  logic signed [15:0] robot_y_i,
  input  logic [15:0]        robot_heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic               goal_is_stop_i,
  input  logic [12:0]        path_curvature_i,
  input  logic [9:0]         elapsed_ms_i,
  output logic signed [15:0] left_power_o,
  output logic signed [15:0] right_power_o,
  output logic signed [15:0] left_target_o,
  output logic signed [15:0] right_target_o
);
  import ddgs_pkg::*;

  localparam int unsigned Steps = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
  // ceil(2^36 / 125): exact floor division by 125 for any 28-bit dividend.
  localparam logic [29:0] Recip125 = 30'd549755814;

  logic signed [35:0] cx_q, cy_q;
  logic [31:0] ang_q;
  logic [4:0]  it_q;
  logic        zero_q, stop_q;
  logic [15:0] head_q;
  logic [12:0] curv_q;
  logic [30:0] sprod_q;
  logic signed [16:0] dx_q, dy_q;
  logic signed [16:0] e_q;
  logic [15:0] mag_q;
  logic [27:0] pa_q;
  logic [24:0] pl_q;
  logic signed [18:0] turn_q;
  logic [32:0] f_q;
  logic [33:0] sq_n_q, sq_r_q;
  logic [4:0]  sq_i_q;
  logic [32:0] dv_rem_q;
  logic [32:0] dv_num_q;
  logic [5:0]  dv_i_q;
  logic [14:0] div_q;
  logic [31:0] quo_q;
  logic signed [15:0] lt_q, rt_q, ll_q, rl_q;
  logic [21:0] step_q;

  // CORDIC step
  logic signed [35:0] sx, sy;
  logic [31:0] arc;
  logic [15:0] bear;
  always_comb begin
    sx = cx_q >>> it_q;
    sy = cy_q >>> it_q;
    arc = arc_of(it_q);
    bear = zero_q ? 16'd0 : 16'((ang_q + 32'h8000) >> 16);
  end

  // square root bit pair (r, bit form)
  logic [33:0] sq_bit, sq_try;
  always_comb begin
    sq_bit = 34'd1 << {sq_i_q, 1'b0};
    sq_try = sq_r_q + sq_bit;
  end

  logic [33:0] dv_sub;
  assign dv_sub = {dv_rem_q[31:0], dv_num_q[32]} - {19'd0, div_q};

  logic signed [34:0] lsum, ldif;
  logic [12:0] cc;
  assign cc = (path_curvature_i > 13'd4096) ? 13'd4096 : path_curvature_i;

  always_comb begin
    lsum = $signed({2'b0, f_q}) + 35'(turn_q);
    ldif = $signed({2'b0, f_q}) - 35'(turn_q);
  end

  function automatic logic signed [15:0] clampp(input logic signed [34:0] v);
    if (v > 35'sd25600) return 16'sd25600;
    if (v < -35'sd25600) return -16'sd25600;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] slewf(input logic signed [15:0] l,
      input logic signed [15:0] t, input logic [21:0] s);
    logic signed [23:0] n;
    if (l < t) begin
      n = 24'(l) + $signed({2'b0, s});
      return (n > 24'(t)) ? t : n[15:0];
    end else if (l > t) begin
      n = 24'(l) - $signed({2'b0, s});
      return (n < 24'(t)) ? t : n[15:0];
    end
    return l;
  endfunction

  logic [15:0] u;
  logic [27:0] m1;
  logic [47:0] m2;
  logic [41:0] m3;
  logic [57:0] sprec;
  logic [21:0] stp;
  always_comb begin
    u = bear - head_q;
    m1 = 28'(ang_gain_i) * 28'(mag_q);
    m2 = {20'd0, pa_q} * 48'(TwoPiQ16);
    m3 = {17'd0, pl_q} * 42'(17'd32768 - {1'b0, mag_q});
    // x/1000 = (x/8)/125, the division by 125 done by a reciprocal multiply
    sprec = 58'(sprod_q[30:3]) * 58'(Recip125);
    stp = sprec[57:36];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ll_q <= '0;
      rl_q <= '0;
    end else if (cmd_i.slew) begin
      ll_q <= slewf(ll_q, lt_q, step_q);
      rl_q <= slewf(rl_q, rt_q, step_q);
    end
  end

  logic signed [16:0] ldx, ldy;
  assign ldx = 17'(goal_x_i) - 17'(robot_x_i);
  assign ldy = 17'(goal_y_i) - 17'(robot_y_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dx_q <= ldx;
      dy_q <= ldy;
      zero_q <= (ldx == 0) && (ldy == 0);
      if (ldx < 0) begin
        cx_q <= -(36'(ldx) <<< 16);
        cy_q <= -(36'(ldy) <<< 16);
        ang_q <= 32'h80000000;
      end else begin
        cx_q <= 36'(ldx) <<< 16;
        cy_q <= 36'(ldy) <<< 16;
        ang_q <= '0;
      end
      it_q <= '0;
      head_q <= robot_heading_i;
      stop_q <= goal_is_stop_i;
      curv_q <= cc;
      // Slew step numerator: rate * ms * 256 plus half of the divisor.
      sprod_q <= 31'(slew_rate_i) * 31'(elapsed_ms_i) * 31'd256 + 31'd500;
      div_q <= (look_i == 0) ? 15'd1 : look_i;
    end
    if (cmd_i.cordic_step) begin
      if (cy_q > 0) begin
        cx_q <= cx_q + sy;
        cy_q <= cy_q - sx;
        ang_q <= ang_q + arc;
      end else begin
        cx_q <= cx_q - sy;
        cy_q <= cy_q + sx;
        ang_q <= ang_q - arc;
      end
      it_q <= it_q + 5'd1;
    end
    if (cmd_i.prod1) begin
      e_q <= {u[15], u};
      mag_q <= u[15] ? 16'(-$signed({1'b1, u})) : u;
      step_q <= stp;
      sq_n_q <= 34'(dx_q * dx_q) + 34'(dy_q * dy_q);
      sq_r_q <= '0;
      sq_i_q <= 5'd16;
    end
    if (cmd_i.prod2) begin
      pa_q <= m1;
      pl_q <= 25'(lin_gain_i) * 25'(13'd4096 - curv_q);
    end
    if (cmd_i.sqrt_step) begin
      if (sq_n_q >= sq_try) begin
        sq_n_q <= sq_n_q - sq_try;
        sq_r_q <= (sq_r_q >> 1) + sq_bit;
      end else begin
        sq_r_q <= sq_r_q >> 1;
      end
      sq_i_q <= sq_i_q - 5'd1;
    end
    if (cmd_i.mix) begin
      lt_q <= clampp(lsum);
      rt_q <= clampp(ldif);
    end
  end

  // Turn and forward terms, taken in the cycle after pa/pl are latched.
  logic signed [18:0] turn_c;
  logic [15:0] f_c;
  logic [17:0] tr;
  always_comb begin
    tr = 18'((m2 + 48'h8000000) >> 28);
    turn_c = e_q[16] ? -$signed({1'b0, tr}) : $signed({1'b0, tr});
    f_c = 16'((m3 + 42'h400000) >> 23);
  end

  logic sqrt_fin;
  assign sqrt_fin = cmd_i.sqrt_step && (sq_i_q == 0);
  logic [33:0] sq_final;
  assign sq_final = (sq_n_q >= sq_try) ? (sq_r_q >> 1) + sq_bit : sq_r_q >> 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.terms) begin
      turn_q <= turn_c;
      f_q <= 33'(f_c);
    end
    if (sqrt_fin) begin
      dv_num_q <= 33'(f_q[15:0]) * 33'(sq_final[16:0]);
      dv_rem_q <= '0;
      dv_i_q <= 6'd33;
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (!dv_sub[33]) dv_rem_q <= dv_sub[32:0];
      else dv_rem_q <= {dv_rem_q[31:0], dv_num_q[32]};
      dv_num_q <= dv_num_q << 1;
      quo_q <= {quo_q[30:0], ~dv_sub[33]};
      dv_i_q <= dv_i_q - 6'd1;
      if (dv_i_q == 6'd1) f_q <= {quo_q, ~dv_sub[33]};
    end
  end

  assign sts_o.cordic_done = cmd_i.cordic_step && (it_q == 5'(Steps - 1));
  assign sts_o.sqrt_done   = sqrt_fin;
  assign sts_o.div_done    = cmd_i.div_step && (dv_i_q == 6'd1);
  assign sts_o.stop        = stop_q;

  assign left_power_o   = ll_q;
  assign right_power_o  = rl_q;
  assign left_target_o  = lt_q;
  assign right_target_o = rt_q;

endmodule

### rtl/diff_drive_goal_steering.sv
// Differential-drive goal steering: bearing by CORDIC, error, turn and forward terms, slew.
// The result is offered after the CORDIC iterations and the product, term, mix and slew
// states, with a 17-step square root and 33-step divide in between on a stopping item.
// One item at a time: a new item is taken only after the previous result has been
// accepted and the controller is back in idle, as these iterative units are shared.
// Reset clears the wheel levels and controller; config registers take their defaults.
module diff_drive_goal_steering #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [14:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] robot_x_i,
  input  logic signed [15:0] robot_y_i,
  input  logic [15:0]        robot_heading_i,
  input  logic signed [15:0] goal_x_i,
  input  logic signed [15:0] goal_y_i,
  input  logic               goal_is_stop_i,
  input  logic [12:0]        path_curvature_i,
  input  logic [9:0]         elapsed_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] left_power_o,
  output logic signed [15:0] right_power_o,
  output logic signed [15:0] left_target_o,
  output logic signed [15:0] right_target_o
);
  import ddgs_pkg::*;

  logic [11:0] ang_gain_q, lin_gain_q, slew_q;
  logic [14:0] look_q;
  cmd_t cmd;
  sts_t sts;

  // Configuration registers; writes are always accepted.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_gain_q <= 12'd800;
      lin_gain_q <= 12'd800;
      slew_q     <= 12'd400;
      look_q     <= 15'd960;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegAngGain: ang_gain_q <= cfg_data_i[11:0];
        RegLinGain: lin_gain_q <= cfg_data_i[11:0];
        RegSlew:    slew_q     <= cfg_data_i[11:0];
        RegLook:    look_q     <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  ddgs_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  ddgs_dp #(.CordicSteps(CORDIC_STEPS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .ang_gain_i(ang_gain_q), .lin_gain_i(lin_gain_q), .slew_rate_i(slew_q),
    .look_i(look_q),
    .robot_x_i, .robot_y_i, .robot_heading_i, .goal_x_i, .goal_y_i,
    .goal_is_stop_i, .path_curvature_i, .elapsed_ms_i,
    .left_power_o, .right_power_o, .left_target_o, .right_target_o
  );

endmodule

### sim/tb_top.sv
// Self-checking testbench for diff_drive_goal_steering.
// Depends on rtl/ddgs_pkg.sv and rtl/diff_drive_goal_steering.sv; uses register codes from the package.
// A predictor or a typed-in expectation checks every result; the register settings change between phases.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CordicSteps = 16;
  localparam longint      CycleLimit  = 3000000;
  // Long enough to cover any work still in flight, also on a stopping item.
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned PowerLimit  = 25600;

  // Binary-angle arcs atan(2^-i), scaled so that 2^32 is a full circle.
  localparam logic [31:0] Arcs [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  // One steering request, with the same widths as the input ports.
  typedef struct {
    logic signed [15:0] rx;
    logic signed [15:0] ry;
    logic [15:0]        hd;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic               stop;
    logic [12:0]        curv;
    logic [9:0]         ms;
  } steer_req_t;

  // One result: levels after the slew and the clamped wheel targets.
  typedef struct {
    logic signed [15:0] lpow;
    logic signed [15:0] rpow;
    logic signed [15:0] ltgt;
    logic signed [15:0] rtgt;
  } wheel_cmd_t;

  // A directed row, with an optional expectation that is typed in directly.
  typedef struct {
    steer_req_t req;
    bit         typed;
    wheel_cmd_t want;
  } steer_row_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = '0;
  logic [14:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] robot_x_i = '0;
  logic signed [15:0] robot_y_i = '0;
  logic [15:0]        robot_heading_i = '0;
  logic signed [15:0] goal_x_i = '0;
  logic signed [15:0] goal_y_i = '0;
  logic               goal_is_stop_i = 1'b0;
  logic [12:0]        path_curvature_i = '0;
  logic [9:0]         elapsed_ms_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] left_power_o;
  logic signed [15:0] right_power_o;
  logic signed [15:0] left_target_o;
  logic signed [15:0] right_target_o;

  // The predictor keeps its own copy of the registers and of the wheel levels.
  longint     ang_gain;
  longint     lin_gain;
  longint     slew_per_s;
  longint     look_dist;
  longint     left_lvl;
  longint     right_lvl;

  wheel_cmd_t wheel_q[$];
  int         fail_cnt = 0;
  int         results_seen = 0;
  int         hold_cnt = 0;
  bit         hold_done = 1'b0;
  bit         rx_eager = 1'b0;
  bit         tx_burst = 1'b0;
  longint     cycle_cnt = 0;

  diff_drive_goal_steering #(
    .CORDIC_STEPS(CordicSteps)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .robot_x_i       (robot_x_i),
    .robot_y_i       (robot_y_i),
    .robot_heading_i (robot_heading_i),
    .goal_x_i        (goal_x_i),
    .goal_y_i        (goal_y_i),
    .goal_is_stop_i  (goal_is_stop_i),
    .path_curvature_i(path_curvature_i),
    .elapsed_ms_i    (elapsed_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .left_power_o    (left_power_o),
    .right_power_o   (right_power_o),
    .left_target_o   (left_target_o),
    .right_target_o  (right_target_o)
  );

  always #6 clk_i = ~clk_i;

  // Vectoring CORDIC: rotate (dx, dy) onto the x axis and sum the arcs used.
  // A goal sitting on the robot has no bearing and reads as zero.
  function automatic logic [15:0] goal_bearing(input longint dx, input longint dy);
    longint      x;
    longint      y;
    longint      nx;
    logic [31:0] ang;
    logic [31:0] rounded;
    begin
      if (dx == 0 && dy == 0) begin
        return 16'd0;
      end
      x = dx * 65536;
      y = dy * 65536;
      ang = 32'd0;
      // Left half plane: turn half a circle first so the iterations converge.
      if (x < 0) begin
        x = -x;
        y = -y;
        ang = 32'h80000000;
      end
      for (int i = 0; i < CordicSteps; i++) begin
        if (y > 0) begin
          nx = x + (y >>> i);
          y = y - (x >>> i);
          ang = ang + Arcs[i];
        end else begin
          nx = x - (y >>> i);
          y = y + (x >>> i);
          ang = ang - Arcs[i];
        end
        x = nx;
      end
      rounded = ang + 32'h8000;
      return rounded[31:16];
    end
  endfunction

  // Integer square root, floor, by the digit-by-digit method.
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    begin
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    end
  endfunction

  function automatic longint power_clamp(input longint v);
    begin
      if (v < -longint'(PowerLimit)) return -longint'(PowerLimit);
      if (v > longint'(PowerLimit)) return longint'(PowerLimit);
      return v;
    end
  endfunction

  // Move a level toward its target by at most one step, never past it.
  function automatic longint slew_toward(input longint lvl, input longint tgt,
                                         input longint step);
    begin
      if (lvl < tgt) begin
        lvl = lvl + step;
        if (lvl > tgt) lvl = tgt;
      end else if (lvl > tgt) begin
        lvl = lvl - step;
        if (lvl < tgt) lvl = tgt;
      end
      return lvl;
    end
  endfunction

  // Works out the wheel command for one request and advances the stored levels.
  function automatic wheel_cmd_t steer_predict(input steer_req_t r);
    longint      dx;
    longint      dy;
    logic [15:0] err_u;
    longint      err;
    longint      mag;
    longint      turn;
    longint      fwd;
    longint      c;
    longint      step;
    longint      lt;
    longint      rt;
    wheel_cmd_t  w;
    begin
      dx = longint'(r.gx) - longint'(r.rx);
      dy = longint'(r.gy) - longint'(r.ry);
      // The heading error wraps into a signed binary angle; half a circle reads negative.
      err_u = goal_bearing(dx, dy) - r.hd;
      err = longint'($signed(err_u));
      mag = (err < 0) ? -err : err;
      turn = (ang_gain * mag * 411775 + (64'd1 << 27)) >>> 28;
      if (err < 0) turn = -turn;
      // Curvature above one saturates.
      c = (r.curv > 13'd4096) ? 4096 : longint'(r.curv);
      fwd = (lin_gain * (4096 - c) * (32768 - mag) + (64'd1 << 22)) >>> 23;
      if (r.stop) begin
        // A zero look-ahead divides as one.
        fwd = fwd * longint'(floor_root(dx * dx + dy * dy)) / ((look_dist == 0) ? 1 : look_dist);
      end
      lt = power_clamp(fwd + turn);
      rt = power_clamp(fwd - turn);
      step = (slew_per_s * longint'(r.ms) * 256 + 500) / 1000;
      left_lvl = slew_toward(left_lvl, lt, step);
      right_lvl = slew_toward(right_lvl, rt, step);
      w.lpow = left_lvl[15:0];
      w.rpow = right_lvl[15:0];
      w.ltgt = lt[15:0];
      w.rtgt = rt[15:0];
      return w;
    end
  endfunction

  function automatic int gap_cycles();
    int unsigned p;
    begin
      if (tx_burst) return 0;
      p = $urandom_range(0, 99);
      if (p < 55) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 12);
      return $urandom_range(25, 80);
    end
  endfunction

  // Most requests put the goal near the robot, as a real path follower would; the rest draw the
  // goal position over its whole range.
  function automatic steer_req_t random_req();
    steer_req_t r;
    int         span;
    begin
      r.rx   = 16'($urandom);
      r.ry   = 16'($urandom);
      r.hd   = 16'($urandom);
      r.gx   = 16'($urandom);
      r.gy   = 16'($urandom);
      r.stop = ($urandom_range(0, 2) == 0);
      r.curv = ($urandom_range(0, 4) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
      r.ms   = ($urandom_range(0, 4) == 0) ? 10'($urandom) : 10'($urandom_range(0, 60));
      if ($urandom_range(0, 3) != 0) begin
        span = ($urandom_range(0, 3) == 0) ? 8 : 3000;
        r.gx = r.rx + 16'($signed($urandom_range(0, 2 * span)) - span);
        r.gy = r.ry + 16'($signed($urandom_range(0, 2 * span)) - span);
        // Now and then aim the robot close to straight at the goal.
        if ($urandom_range(0, 3) == 0) begin
          r.hd = goal_bearing(longint'(r.gx) - longint'(r.rx),
                              longint'(r.gy) - longint'(r.ry)) + 16'($urandom_range(0, 64));
        end
      end
      return r;
    end
  endfunction

  // Offer one request and hold it until the transfer; queue its expected command.
  task automatic send_req(input steer_req_t r, input bit typed, input wheel_cmd_t want);
    int         gap;
    bit         rdy;
    wheel_cmd_t w;
    begin
      gap = gap_cycles();
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i       <= 1'b1;
      robot_x_i        <= r.rx;
      robot_y_i        <= r.ry;
      robot_heading_i  <= r.hd;
      goal_x_i         <= r.gx;
      goal_y_i         <= r.gy;
      goal_is_stop_i   <= r.stop;
      path_curvature_i <= r.curv;
      elapsed_ms_i     <= r.ms;
      // Ready is sampled mid-cycle, where it is settled for the coming edge.
      do begin
        @(negedge clk_i);
        rdy = in_ready_o;
        @(posedge clk_i);
      end while (!rdy);
      // The predictor always runs so the stored levels keep step with the block.
      w = steer_predict(r);
      wheel_q.push_back(typed ? want : w);
    end
  endtask

  // Registers change only while the block is idle and no result is outstanding.
  task automatic write_reg(input logic [1:0] idx, input logic [14:0] data);
    bit rdy;
    begin
      in_valid_i <= 1'b0;
      while (wheel_q.size() != 0) @(posedge clk_i);
      repeat (DrainCycles) @(posedge clk_i);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do begin
        @(negedge clk_i);
        rdy = cfg_ready_o;
        @(posedge clk_i);
      end while (!rdy);
      cfg_valid_i <= 1'b0;
      case (idx)
        ddgs_pkg::RegAngGain: ang_gain = longint'(data[11:0]);
        ddgs_pkg::RegLinGain: lin_gain = longint'(data[11:0]);
        ddgs_pkg::RegSlew:    slew_per_s = longint'(data[11:0]);
        default:              look_dist = longint'(data);
      endcase
    end
  endtask

  task automatic set_regs(input logic [14:0] ag, input logic [14:0] lg,
                          input logic [14:0] sr, input logic [14:0] la);
    begin
      write_reg(ddgs_pkg::RegAngGain, ag);
      write_reg(ddgs_pkg::RegLinGain, lg);
      write_reg(ddgs_pkg::RegSlew, sr);
      write_reg(ddgs_pkg::RegLook, la);
    end
  endtask

  task automatic random_phase(input int count);
    wheel_cmd_t none;
    begin
      none = '{default: '0};
      tx_burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < count; k++) begin
        if (k % 60 == 0) tx_burst = ($urandom_range(0, 3) == 0);
        send_req(random_req(), 1'b0, none);
      end
    end
  endtask

  // The receiver stalls at random, runs eager for stretches, and once holds off for a long
  // time while the sender keeps offering, so that the block backs up onto its input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_ready_i <= 1'b0;
      end else if (!hold_done && results_seen >= 200) begin
        hold_done <= 1'b1;
        hold_cnt <= 600;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 199) == 0) rx_eager <= ~rx_eager;
        if (rx_eager) begin
          out_ready_i <= 1'b1;
        end else begin
          case ($urandom_range(0, 19))
            0:       out_ready_i <= 1'b0;
            1, 2, 3: out_ready_i <= ($urandom_range(0, 9) == 0);
            default: out_ready_i <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // Result checking against the oldest outstanding expectation.
  always @(posedge clk_i) begin
    wheel_cmd_t w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen <= results_seen + 1;
      if (wheel_q.size() == 0) begin
        $display("%0t: result with nothing expected: %0d %0d %0d %0d", $time,
                 left_power_o, right_power_o, left_target_o, right_target_o);
        fail_cnt <= fail_cnt + 1;
      end else begin
        w = wheel_q.pop_front();
        if (left_power_o !== w.lpow || right_power_o !== w.rpow ||
            left_target_o !== w.ltgt || right_target_o !== w.rtgt) begin
          $display("%0t: expected %0d %0d %0d %0d, got %0d %0d %0d %0d", $time,
                   w.lpow, w.rpow, w.ltgt, w.rtgt,
                   left_power_o, right_power_o, left_target_o, right_target_o);
          fail_cnt <= fail_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    steer_row_t rows[$];
    steer_row_t row;
    wheel_cmd_t none;

    none = '{default: '0};
    ang_gain = 800;
    lin_gain = 800;
    slew_per_s = 400;
    look_dist = 960;
    left_lvl = 0;
    right_lvl = 0;

    // Directed rows, run with the registers at their reset values. The first two hold the
    // levels at zero and then jump straight to the targets, so their results are typed in.
    // Goal on the robot, heading zero: no turn, forward term of 12800, no time passed.
    rows.push_back('{'{0, 0, 16'd0, 0, 0, 1'b0, 13'd0, 10'd0}, 1'b1,
                     '{16'sd0, 16'sd0, 16'sd12800, 16'sd12800}});
    // Error of exactly half a circle: the negative turn saturates the targets, forward term is zero.
    rows.push_back('{'{0, 0, 16'd32768, 0, 0, 1'b0, 13'd0, 10'd1023}, 1'b1,
                     '{-16'sd25600, 16'sd25600, -16'sd25600, 16'sd25600}});
    rows.push_back('{'{-16'sd32768, -16'sd32768, 16'd0, 16'sd32767, 16'sd32767, 1'b0,
                       13'd0, 10'd1023}, 1'b0, none});
    rows.push_back('{'{16'sd32767, 16'sd32767, 16'd65535, -16'sd32768, -16'sd32768, 1'b1,
                       13'd4096, 10'd1}, 1'b0, none});
    // Curvature above one saturates.
    rows.push_back('{'{0, 0, 16'd16384, 0, 16'sd500, 1'b0, 13'd8191, 10'd10}, 1'b0, none});
    rows.push_back('{'{0, 0, 16'd16384, 0, 16'sd500, 1'b0, 13'd4097, 10'd10}, 1'b0, none});
    // Stopping with the goal on the robot gives no forward power.
    rows.push_back('{'{16'sd100, -16'sd100, 16'd0, 16'sd100, -16'sd100, 1'b1, 13'd0,
                       10'd500}, 1'b0, none});
    rows.push_back('{'{0, 0, 16'd0, 16'sd480, 0, 1'b1, 13'd0, 10'd1023}, 1'b0, none});
    rows.push_back('{'{0, 0, 16'd0, -16'sd480, 0, 1'b1, 13'd2048, 10'd300}, 1'b0, none});
    rows.push_back('{'{0, 0, 16'd49152, 0, -16'sd960, 1'b0, 13'd100, 10'd20}, 1'b0, none});
    rows.push_back('{'{0, 0, 16'd32767, -16'sd1, 0, 1'b0, 13'd0, 10'd40}, 1'b0, none});
    rows.push_back('{'{0, 0, 16'd0, 16'sd1, 16'sd1, 1'b1, 13'd1, 10'd512}, 1'b0, none});
    rows.push_back('{'{-16'sd1, 16'sd1, 16'd8192, 16'sd32767, -16'sd32768, 1'b1, 13'd4095,
                       10'd1023}, 1'b0, none});

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[n]) begin
      row = rows[n];
      send_req(row.req, row.typed, row.want);
    end

    random_phase(300);
    // Largest values; the two gain registers also see their unused upper data bits set.
    set_regs(15'h7FFF, 15'h7FFF, 15'd4095, 15'd32767);
    random_phase(250);
    // Zero gains and slew, and a zero look-ahead that divides as one.
    set_regs(15'd0, 15'd0, 15'd0, 15'd0);
    random_phase(150);
    set_regs(15'd4095, 15'd800, 15'd4000, 15'd64);
    random_phase(250);
    set_regs(15'($urandom_range(0, 4095)), 15'($urandom_range(0, 4095)),
             15'($urandom_range(0, 4000)), 15'($urandom_range(64, 32767)));
    random_phase(250);
    set_regs(15'd800, 15'd800, 15'd400, 15'd960);
    random_phase(200);

    in_valid_i <= 1'b0;
    while (wheel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
